FILE: src/llrm_pkg.sv
`default_nettype none

package llrm_pkg;

  localparam int ADDR_W     = 32;
  localparam int CTX_PORT_W = 8;
  localparam int COUNT_W    = 32;

  // The line bitmap is stored as rows of 32 bits.
  localparam int BM_ROW_LOG = 5;
  localparam int BM_ROW_W   = 1 << BM_ROW_LOG;

  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_UNREG   = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_NOTIFY  = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic bm_clear;
    logic bm_set;
    logic res_record;
    logic capture_query;
    logic slot_take;
    logic slot_release;
    logic set_full;
    logic idx_clr;
    logic idx_inc;
    logic notify_step;
    logic emit_final;
  } llrm_cmd_t;

  typedef struct packed {
    logic  clear_done;
    logic  slot_hit;
    logic  slot_free;
    logic  idx_last;
    logic  loss;
    logic  pend_valid;
    logic  out_free;
    kind_t item_kind;
    logic  item_present;
  } llrm_status_t;

endpackage

`default_nettype wire

FILE: src/lock_line_reservation_monitor.sv
// Sequence to the final word: an unregister without a context goes straight to it, a query
// reads the bitmap row, a reserve reads and writes it, an unregister or a reserve with a context
// also scans the registry slots, and a notify reads and compares each slot in turn; output stalls add delay.
// Throughput: one item at a time; in_stall stays high until the item's final word is issued.
// Reset: the line bitmap is cleared one 32-bit row per cycle over all 2^(LINE_INDEX_BITS-5)
// rows (1024 by default), with in_stall high until the pass is done.
`default_nettype none

module lock_line_reservation_monitor
  import llrm_pkg::*;
#(
  parameter int SLOTS           = 8,
  parameter int LINE_INDEX_BITS = 15,
  parameter int LINE_SHIFT      = 7,
  parameter int CONTEXT_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_kind,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [CTX_PORT_W-1:0] in_context_id,
  input  wire logic                  in_context_present,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_line_reserved,
  output logic                       out_lost_valid,
  output logic [CTX_PORT_W-1:0]      out_lost_context,
  output logic                       out_registry_full,
  output logic [COUNT_W-1:0]         out_raise_count,
  output logic                       out_last
);

  llrm_cmd_t    cmd;
  llrm_status_t status;

  llrm_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_kind            (in_kind),
    .in_context_present (in_context_present),
    .in_stall           (in_stall),
    .status             (status),
    .cmd                (cmd)
  );

  llrm_datapath #(
    .SLOTS           (SLOTS),
    .LINE_INDEX_BITS (LINE_INDEX_BITS),
    .LINE_SHIFT      (LINE_SHIFT),
    .CONTEXT_BITS    (CONTEXT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_address         (in_address),
    .in_context_id      (in_context_id),
    .in_context_present (in_context_present),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_line_reserved  (out_line_reserved),
    .out_lost_valid     (out_lost_valid),
    .out_lost_context   (out_lost_context),
    .out_registry_full  (out_registry_full),
    .out_raise_count    (out_raise_count),
    .out_last           (out_last),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

`default_nettype wire

FILE: src/llrm_ctrl.sv
`default_nettype none

module llrm_ctrl
  import llrm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [1:0]   in_kind,
  input  wire logic         in_context_present,
  output logic              in_stall,
  input  wire llrm_status_t status,
  output llrm_cmd_t         cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_BMRD  = 8'b0000_0100,
    ST_BMWR  = 8'b0000_1000,
    ST_SLOT  = 8'b0001_0000,
    ST_NREAD = 8'b0010_0000,
    ST_NCMP  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  in_kind_c;

  assign in_kind_c = kind_t'(in_kind);
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.bm_clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (in_kind_c)
            KIND_RESERVE, KIND_QUERY: state_nxt = ST_BMRD;
            KIND_UNREG:  state_nxt = in_context_present ? ST_SLOT : ST_DONE;
            KIND_NOTIFY: state_nxt = ST_NREAD;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_BMRD: begin
        if (status.item_kind == KIND_RESERVE && status.item_present) begin
          cmd.res_record = 1'b1;
        end
        state_nxt = ST_BMWR;
      end
      ST_BMWR: begin
        if (status.item_kind == KIND_RESERVE) begin
          cmd.bm_set = 1'b1;
          state_nxt  = status.item_present ? ST_SLOT : ST_DONE;
        end else begin
          cmd.capture_query = 1'b1;
          state_nxt         = ST_DONE;
        end
      end
      ST_SLOT: begin
        if (status.item_kind == KIND_RESERVE) begin
          if (status.slot_hit) begin
            state_nxt = ST_DONE;
          end else if (status.slot_free) begin
            cmd.slot_take = 1'b1;
            state_nxt     = ST_DONE;
          end else if (status.idx_last) begin
            cmd.set_full = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          if (status.slot_hit) begin
            cmd.slot_release = 1'b1;
            state_nxt        = ST_DONE;
          end else if (status.idx_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_NREAD: begin
        state_nxt = ST_NCMP;
      end
      ST_NCMP: begin
        // A second loss must wait until the held one can go to the output.
        if (!(status.loss && status.pend_valid && !status.out_free)) begin
          cmd.notify_step = 1'b1;
          if (status.idx_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_NREAD;
          end
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/llrm_datapath.sv
`default_nettype none

module llrm_datapath
  import llrm_pkg::*;
#(
  parameter int SLOTS           = 8,
  parameter int LINE_INDEX_BITS = 15,
  parameter int LINE_SHIFT      = 7,
  parameter int CONTEXT_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [1:0]            in_kind,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [CTX_PORT_W-1:0] in_context_id,
  input  wire logic                  in_context_present,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_line_reserved,
  output logic                       out_lost_valid,
  output logic [CTX_PORT_W-1:0]      out_lost_context,
  output logic                       out_registry_full,
  output logic [COUNT_W-1:0]         out_raise_count,
  output logic                       out_last,
  input  wire llrm_cmd_t             cmd,
  output llrm_status_t               status
);

  localparam int LINE_W   = ADDR_W - LINE_SHIFT;
  localparam int IDX_SRC_W = (LINE_W > LINE_INDEX_BITS) ? LINE_W : LINE_INDEX_BITS;
  localparam int ROW_AW   = LINE_INDEX_BITS - BM_ROW_LOG;
  localparam int ROWS     = 1 << ROW_AW;
  localparam int CTXS     = 1 << CONTEXT_BITS;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Accepted item.
  kind_t                    item_kind_r;
  logic [LINE_W-1:0]        item_line_r;
  logic [CONTEXT_BITS-1:0]  item_ctx_r;
  logic                     item_present_r;

  // Line bitmap, one row per memory word.
  logic [BM_ROW_W-1:0]      bm_mem [ROWS];
  logic [BM_ROW_W-1:0]      bm_q_r;
  logic [ROW_AW-1:0]        clear_cnt_r;
  logic [IDX_SRC_W-1:0]     line_ext;
  logic [LINE_INDEX_BITS-1:0] line_idx;
  logic [ROW_AW-1:0]        item_row;
  logic [BM_ROW_LOG-1:0]    item_bit;
  logic                     bm_we;
  logic [ROW_AW-1:0]        bm_waddr;
  logic [BM_ROW_W-1:0]      bm_wdata;

  // Per-context reservations.
  logic [CTXS-1:0]          rv_r;
  logic [LINE_W-1:0]        rl_mem [CTXS];
  logic [LINE_W-1:0]        rl_q_r;

  // Registry.
  logic [SLOTS-1:0]         used_r;
  logic [CONTEXT_BITS-1:0]  owner_r [SLOTS];
  logic [SLOT_W-1:0]        idx_r;
  logic [CONTEXT_BITS-1:0]  cur_owner;
  logic                     cur_used;
  logic                     owner_match;

  // Counter, held loss and final result fields.
  logic [COUNT_W-1:0]       lost_cnt_r;
  logic [COUNT_W-1:0]       lost_cnt_inc;
  logic                     pend_valid_r;
  logic [CONTEXT_BITS-1:0]  pend_ctx_r;
  logic [COUNT_W-1:0]       pend_count_r;
  logic                     res_reserved_r;
  logic                     res_full_r;
  logic                     loss;
  logic                     out_free;
  logic                     push_loss;

  assign line_ext    = IDX_SRC_W'(item_line_r);
  assign line_idx    = line_ext[LINE_INDEX_BITS-1:0];
  assign item_row    = line_idx[LINE_INDEX_BITS-1:BM_ROW_LOG];
  assign item_bit    = line_idx[BM_ROW_LOG-1:0];

  assign cur_owner   = owner_r[idx_r];
  assign cur_used    = used_r[idx_r];
  assign owner_match = (cur_owner == item_ctx_r);
  assign loss        = cur_used && !(item_present_r && owner_match) &&
                       rv_r[cur_owner] && (rl_q_r == item_line_r);
  assign lost_cnt_inc = lost_cnt_r + COUNT_W'(1);
  assign out_free    = !out_valid || !out_stall;
  assign push_loss   = cmd.notify_step && loss && pend_valid_r;

  assign status.clear_done   = &clear_cnt_r;
  assign status.slot_hit     = cur_used && owner_match;
  assign status.slot_free    = !cur_used;
  assign status.idx_last     = (idx_r == SLOT_W'(SLOTS - 1));
  assign status.loss         = loss;
  assign status.pend_valid   = pend_valid_r;
  assign status.out_free     = out_free;
  assign status.item_kind    = item_kind_r;
  assign status.item_present = item_present_r;

  // Bitmap memory: clearing pass after reset, read-modify-write on reserve.
  assign bm_we    = cmd.bm_clear || cmd.bm_set;
  assign bm_waddr = cmd.bm_clear ? clear_cnt_r : item_row;
  assign bm_wdata = cmd.bm_clear ? '0 :
                    (bm_q_r | (BM_ROW_W'(1) << item_bit));

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_q_r <= bm_mem[item_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_record) begin
      rl_mem[item_ctx_r] <= item_line_r;
    end
    rl_q_r <= rl_mem[cur_owner];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_cnt_r <= '0;
    end else if (cmd.bm_clear) begin
      clear_cnt_r <= clear_cnt_r + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind_r    <= kind_t'(in_kind);
      item_line_r    <= in_address[ADDR_W-1:LINE_SHIFT];
      item_ctx_r     <= in_context_id[CONTEXT_BITS-1:0];
      item_present_r <= in_context_present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (cmd.res_record) begin
      rv_r[item_ctx_r] <= 1'b1;
    end else if (cmd.notify_step && loss) begin
      rv_r[cur_owner] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.slot_take) begin
      used_r[idx_r] <= 1'b1;
    end else if (cmd.slot_release) begin
      used_r[idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_take) begin
      owner_r[idx_r] <= item_ctx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.load) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.notify_step && loss) begin
      lost_cnt_r   <= lost_cnt_inc;
      pend_valid_r <= 1'b1;
    end
  end

  // A loss is held until the next one or the end of the scan decides its last flag.
  always_ff @(posedge clk) begin
    if (cmd.notify_step && loss) begin
      pend_ctx_r   <= cur_owner;
      pend_count_r <= lost_cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_reserved_r <= 1'b0;
      res_full_r     <= 1'b0;
    end else begin
      if (cmd.capture_query) begin
        res_reserved_r <= bm_q_r[item_bit];
      end
      if (cmd.set_full) begin
        res_full_r <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (push_loss || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_loss) begin
      out_line_reserved <= 1'b0;
      out_lost_valid    <= 1'b1;
      out_lost_context  <= CTX_PORT_W'(pend_ctx_r);
      out_registry_full <= 1'b0;
      out_raise_count   <= pend_count_r;
      out_last          <= 1'b0;
    end else if (cmd.emit_final) begin
      out_line_reserved <= res_reserved_r;
      out_lost_valid    <= pend_valid_r;
      out_lost_context  <= pend_valid_r ? CTX_PORT_W'(pend_ctx_r) : '0;
      out_registry_full <= res_full_r;
      out_raise_count   <= pend_valid_r ? pend_count_r : lost_cnt_r;
      out_last          <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_lock_line_reservation_monitor.sv
`default_nettype none

module tb_lock_line_reservation_monitor
  import llrm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic        line_reserved;
    logic        lost_valid;
    logic [7:0]  lost_context;
    logic        registry_full;
    logic [31:0] raise_count;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_QUERY;
  logic [31:0] in_address = '0;
  logic [7:0]  in_context_id = '0;
  logic        in_context_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_line_reserved;
  logic        out_lost_valid;
  logic [7:0]  out_lost_context;
  logic        out_registry_full;
  logic [31:0] out_raise_count;
  logic        out_last;

  lock_line_reservation_monitor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_address         (in_address),
    .in_context_id      (in_context_id),
    .in_context_present (in_context_present),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_line_reserved  (out_line_reserved),
    .out_lost_valid     (out_lost_valid),
    .out_lost_context   (out_lost_context),
    .out_registry_full  (out_registry_full),
    .out_raise_count    (out_raise_count),
    .out_last           (out_last)
  );

  always #4 clk = ~clk;

  // Shadow copy of the monitor state.
  bit          line_bits [0:32767];
  bit          slot_used [NUM_SLOTS];
  logic [7:0]  slot_owner [NUM_SLOTS];
  bit          resv_held [256];
  logic [24:0] resv_line [256];
  logic [31:0] raise_total = '0;

  word_t       pending_words [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  logic [24:0] line_pool [6];
  logic [7:0]  ctx_pool [12];

  task automatic track_reservations(kind_t k, logic [31:0] addr, logic [7:0] ctx, logic present);
    logic [24:0] line;
    logic [14:0] idx;
    word_t       w;
    word_t       losses [$];
    bit          done;
    logic [7:0]  owner;
    line = addr[31:7];
    idx = line[14:0];
    w = '0;
    w.last = 1'b1;
    done = 1'b0;
    case (k)
      KIND_RESERVE: begin
        line_bits[idx] = 1'b1;
        if (present) begin
          resv_held[ctx] = 1'b1;
          resv_line[ctx] = line;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!done) begin
              if (slot_used[i] && slot_owner[i] == ctx) begin
                done = 1'b1;
              end else if (!slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_owner[i] = ctx;
                done = 1'b1;
              end
            end
          end
          w.registry_full = !done;
        end
      end
      KIND_UNREG: begin
        if (present) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!done && slot_used[i] && slot_owner[i] == ctx) begin
              slot_used[i] = 1'b0;
              done = 1'b1;
            end
          end
        end
      end
      KIND_QUERY: begin
        w.line_reserved = line_bits[idx];
      end
      KIND_NOTIFY: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i]) begin
            owner = slot_owner[i];
            if (!(present && owner == ctx) && resv_held[owner] && resv_line[owner] == line) begin
              resv_held[owner] = 1'b0;
              raise_total = raise_total + 1;
              losses.push_back('{1'b0, 1'b1, owner, 1'b0, raise_total, 1'b0});
            end
          end
        end
      end
    endcase
    w.raise_count = raise_total;
    if (losses.size() == 0) begin
      pending_words.push_back(w);
    end else begin
      losses[losses.size()-1].last = 1'b1;
      foreach (losses[i]) pending_words.push_back(losses[i]);
    end
  endtask

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(kind_t k, logic [31:0] addr, logic [7:0] ctx, logic present);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_address <= addr;
    in_context_id <= ctx;
    in_context_present <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_reservations(k, addr, ctx, present);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("line_reserved", 32'(want.line_reserved), 32'(out_line_reserved));
        check_field("lost_valid", 32'(want.lost_valid), 32'(out_lost_valid));
        check_field("lost_context", 32'(want.lost_context), 32'(out_lost_context));
        check_field("registry_full", 32'(want.registry_full), 32'(out_registry_full));
        check_field("raise_count", want.raise_count, out_raise_count);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lock_line_reservation_monitor: done, errors");
      $finish;
    end
  end

  task automatic test_clear_bitmap();
    send_word(KIND_QUERY, 32'h0000_0000, 8'd0, 1'b0);
    send_word(KIND_QUERY, 32'hFFFF_FFFF, 8'd255, 1'b1);
  endtask

  task automatic test_reserve_bitmap();
    // The line index uses address bits 21 to 7 only, so the second address aliases.
    send_word(KIND_RESERVE, 32'hFFFF_FFFF, 8'd7, 1'b0);
    send_word(KIND_QUERY, 32'h003F_FF80, 8'd0, 1'b0);
  endtask

  task automatic test_notify_except();
    send_word(KIND_RESERVE, 32'h1234_5680, 8'd0, 1'b1);
    send_word(KIND_RESERVE, 32'h1234_56FF, 8'd255, 1'b1);
    send_word(KIND_NOTIFY, 32'h1234_5690, 8'd0, 1'b1);
    send_word(KIND_NOTIFY, 32'h1234_5680, 8'd0, 1'b0);
  endtask

  task automatic test_registry_full();
    for (int i = 0; i < 6; i++) begin
      send_word(KIND_RESERVE, 32'h4000_0000 + i * 128, 8'(10 + i), 1'b1);
    end
    send_word(KIND_RESERVE, 32'h5000_0000, 8'd20, 1'b1);
    // The context is not registered, so its recorded reservation is never lost.
    send_word(KIND_NOTIFY, 32'h5000_0040, 8'd0, 1'b0);
  endtask

  task automatic test_unregister();
    send_word(KIND_UNREG, 32'h0000_0000, 8'd99, 1'b1);
    send_word(KIND_UNREG, 32'h0000_0000, 8'd10, 1'b0);
  endtask

  task automatic test_duplicate_slot();
    // Slot 0 frees up ahead of the slot that holds 255, so 255 ends up in both.
    send_word(KIND_UNREG, 32'h0000_0000, 8'd0, 1'b1);
    send_word(KIND_RESERVE, 32'h0BAD_F000, 8'd255, 1'b1);
    send_word(KIND_NOTIFY, 32'h0BAD_F07F, 8'd3, 1'b1);
  endtask

  task automatic test_multi_loss();
    send_word(KIND_RESERVE, 32'hCAFE_0100, 8'd10, 1'b1);
    send_word(KIND_RESERVE, 32'hCAFE_0104, 8'd12, 1'b1);
    send_word(KIND_NOTIFY, 32'hCAFE_0170, 8'd11, 1'b1);
  endtask

  task automatic test_random_traffic(int count);
    kind_t       k;
    logic [31:0] addr;
    logic [7:0]  ctx;
    logic        present;
    int          roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        k = kind_t'($urandom_range(3));
        addr = $urandom();
        ctx = 8'($urandom_range(255));
        present = 1'($urandom_range(1));
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) k = KIND_RESERVE;
        else if (roll < 50) k = KIND_UNREG;
        else if (roll < 70) k = KIND_QUERY;
        else k = KIND_NOTIFY;
        addr = {line_pool[$urandom_range(5)], 7'($urandom_range(127))};
        ctx = ctx_pool[$urandom_range(11)];
        present = (k == KIND_NOTIFY) ? 1'($urandom_range(1)) : ($urandom_range(9) != 0);
      end
      send_word(k, addr, ctx, present);
    end
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  initial begin
    line_pool[0] = 25'($urandom());
    line_pool[1] = {~line_pool[0][24:15], line_pool[0][14:0]};
    for (int i = 2; i < 6; i++) line_pool[i] = 25'($urandom());
    ctx_pool[0] = 8'd0;
    ctx_pool[1] = 8'd255;
    for (int i = 2; i < 12; i++) ctx_pool[i] = 8'($urandom_range(255));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clear_bitmap();
    test_reserve_bitmap();
    test_notify_except();
    test_registry_full();
    test_unregister();
    test_duplicate_slot();
    test_multi_loss();
    test_random_traffic(60);
    test_drain_pause();
    quiet = 1'b1;
    test_random_traffic(36);
    quiet = 1'b0;
    test_random_traffic(50);

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_lock_line_reservation_monitor: done, clean");
    end else begin
      $display("tb_lock_line_reservation_monitor: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
